### hdl/tkda_pkg.sv
// Shared types and constants for the two-key debounce and auto-repeat block.
`default_nettype none

package tkda_pkg;

  // Key pattern codes: bit 0 = down key pressed, bit 1 = up key pressed.
  localparam logic [1:0] PAT_RELEASED = 2'd0;
  localparam logic [1:0] PAT_DOWN     = 2'd1;
  localparam logic [1:0] PAT_UP       = 2'd2;
  localparam logic [1:0] PAT_BOTH     = 2'd3;

  // Stored patterns carry one more bit for the "no pattern yet" marker.
  localparam logic [2:0] PAT_NONE     = 3'd4;

  // Step codes on the result channel.
  localparam logic signed [1:0] STEP_ZERO  = 2'sd0;
  localparam logic signed [1:0] STEP_PLUS  = 2'sd1;
  localparam logic signed [1:0] STEP_MINUS = -2'sd1;

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_ENABLED      = 2'd0,
    REG_DEBOUNCE     = 2'd1,
    REG_START_DELAY  = 2'd2,
    REG_INTERVAL     = 2'd3
  } reg_index_t;

  // Register reset values.
  localparam logic        ENABLED_RST     = 1'b0;
  localparam logic [15:0] DEBOUNCE_RST    = 16'd80;
  localparam logic [15:0] START_DELAY_RST = 16'd600;
  localparam logic [15:0] INTERVAL_RST    = 16'd200;

  // One classified poll, as it travels from the front to the back.
  typedef struct packed {
    logic [31:0] now_ms;
    logic [1:0]  raw;
    logic        levels_valid;
  } poll_t;

  // Queue status seen by its neighbours.
  typedef struct packed {
    logic not_empty;
    logic full;
  } q_status_t;

  // Configuration as seen by the back end.
  typedef struct packed {
    logic        enabled;
    logic [15:0] debounce_time;
    logic [15:0] repeat_start_delay;
    logic [15:0] repeat_interval;
  } cfg_t;

endpackage

`default_nettype wire

### hdl/tkda_front.sv
// Front end: accept polls and turn the pin levels into a key pattern.
`default_nettype none

module tkda_front (
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [31:0]       now_ms,
  input  wire logic              key_down_low,
  input  wire logic              key_up_low,
  input  wire logic              levels_valid,
  input  wire tkda_pkg::q_status_t q_status,
  output logic                   push,
  output tkda_pkg::poll_t        push_item
);

  // Hold off the sender while the queue has no free entry.
  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full;

  always_comb begin
    push_item.now_ms       = now_ms;
    push_item.raw          = {~key_up_low, ~key_down_low};
    push_item.levels_valid = levels_valid;
  end

endmodule

`default_nettype wire

### hdl/tkda_queue.sv
// Short queue of classified polls between front and back ends.
`default_nettype none

module tkda_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire tkda_pkg::poll_t   push_item,
  input  wire logic              pop,
  output tkda_pkg::poll_t        head_item,
  output tkda_pkg::q_status_t    status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tkda_pkg::poll_t  entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head_item        = entries[rd_ptr];
  assign status.not_empty = (count != '0);
  assign status.full      = (count == CNT_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/tkda_back.sv
// Back end: debounce, arming and auto-repeat state with the result register.
`default_nettype none

module tkda_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire tkda_pkg::cfg_t      cfg,
  input  wire tkda_pkg::q_status_t q_status,
  input  wire tkda_pkg::poll_t     head_item,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic signed [1:0]        step
);

  logic        armed;
  logic [2:0]  candidate_pattern;
  logic [2:0]  stable_pattern;
  logic [1:0]  active_key;
  logic [31:0] candidate_since;
  logic [31:0] repeat_due;

  logic        armed_next;
  logic [2:0]  candidate_pattern_next;
  logic [2:0]  stable_pattern_next;
  logic [1:0]  active_key_next;
  logic [31:0] candidate_since_next;
  logic [31:0] repeat_due_next;
  logic signed [1:0] step_next;

  logic [1:0]  raw;
  logic [31:0] held_for;
  logic [31:0] past_due;
  logic        chord;
  logic signed [1:0] key_step;

  // Take the head item whenever the result register is free or draining.
  assign pop = q_status.not_empty && (!out_valid || !out_stall);

  assign raw      = head_item.raw;
  assign held_for = head_item.now_ms - candidate_since;
  assign past_due = head_item.now_ms - repeat_due;
  assign chord    = (raw == tkda_pkg::PAT_BOTH) ||
                    (active_key != tkda_pkg::PAT_RELEASED &&
                     raw != tkda_pkg::PAT_RELEASED && raw != active_key);
  assign key_step = (raw == tkda_pkg::PAT_DOWN) ? tkda_pkg::STEP_MINUS
                                                : tkda_pkg::STEP_PLUS;

  always_comb begin
    armed_next             = armed;
    candidate_pattern_next = candidate_pattern;
    stable_pattern_next    = stable_pattern;
    active_key_next        = active_key;
    candidate_since_next   = candidate_since;
    repeat_due_next        = repeat_due;
    step_next              = tkda_pkg::STEP_ZERO;

    if (cfg.enabled) begin
      if (!head_item.levels_valid) begin
        armed_next             = 1'b0;
        candidate_pattern_next = tkda_pkg::PAT_NONE;
        stable_pattern_next    = tkda_pkg::PAT_NONE;
        active_key_next        = tkda_pkg::PAT_RELEASED;
        candidate_since_next   = '0;
        repeat_due_next        = '0;
      end else begin
        // Drop repeat and disarm at once on a chord or rollover.
        if (chord) begin
          armed_next      = 1'b0;
          active_key_next = tkda_pkg::PAT_RELEASED;
        end
        if ({1'b0, raw} != candidate_pattern) begin
          candidate_pattern_next = {1'b0, raw};
          candidate_since_next   = head_item.now_ms;
        end else if (held_for < {16'd0, cfg.debounce_time}) begin
          // still bouncing
        end else if (stable_pattern != {1'b0, raw}) begin
          stable_pattern_next = {1'b0, raw};
          if (raw == tkda_pkg::PAT_RELEASED) begin
            armed_next      = 1'b1;
            active_key_next = tkda_pkg::PAT_RELEASED;
          end else if (armed_next && raw != tkda_pkg::PAT_BOTH) begin
            active_key_next = raw;
            repeat_due_next = head_item.now_ms + {16'd0, cfg.repeat_start_delay};
            step_next       = key_step;
          end
        end else if (armed_next && active_key_next != tkda_pkg::PAT_RELEASED &&
                     raw == active_key_next && !past_due[31]) begin
          repeat_due_next = head_item.now_ms + {16'd0, cfg.repeat_interval};
          step_next       = key_step;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed             <= 1'b0;
      candidate_pattern <= tkda_pkg::PAT_NONE;
      stable_pattern    <= tkda_pkg::PAT_NONE;
      active_key        <= tkda_pkg::PAT_RELEASED;
      candidate_since   <= '0;
      repeat_due        <= '0;
      out_valid         <= 1'b0;
    end else begin
      if (pop) begin
        armed             <= armed_next;
        candidate_pattern <= candidate_pattern_next;
        stable_pattern    <= stable_pattern_next;
        active_key        <= active_key_next;
        candidate_since   <= candidate_since_next;
        repeat_due        <= repeat_due_next;
        out_valid         <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      step <= step_next;
    end
  end

endmodule

`default_nettype wire

### hdl/two_key_debounce_autorepeat.sv
// Top level of the two-key debounce and auto-repeat block with its register port.
//
// Usage:
//   Polls enter on the input channel (in_valid / in_stall) carrying now_ms,
//   the two active-low key levels and levels_valid. Every accepted poll gives
//   exactly one transfer on the output channel (out_valid / out_stall) with
//   step = -1 (down), +1 (up) or 0.
//   An accepted poll is written into the queue; the back end takes it from the
//   queue head into the result register, which drives the result channel.
//   Throughput: one poll per cycle while out_stall is low; the back end does
//   each poll's whole state update as it pops it, so polls may follow back to back.
//   A front end classifies polls into a QUEUE_DEPTH-entry queue; the back end
//   drains it into a result register. When the receiver stalls, the result
//   register holds its transfer, the queue fills and in_stall rises once it
//   is full; nothing is lost or repeated.
//   Reset (rst, synchronous) empties the queue, drops any pending result,
//   clears the debounce state and reloads the registers with their defaults
//   (disabled, 80 ms debounce, 600 ms start delay, 200 ms interval).
//   Registers sit at byte addresses 0, 4, 8 and 12 of the APB-style port;
//   write them only while no poll is in flight.
`default_nettype none

module two_key_debounce_autorepeat #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // poll channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [31:0]       now_ms,
  input  wire logic              key_down_low,
  input  wire logic              key_up_low,
  input  wire logic              levels_valid,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic signed [1:0]      step,
  // register port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [3:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  tkda_pkg::cfg_t      cfg;
  tkda_pkg::q_status_t q_status;
  tkda_pkg::poll_t     push_item;
  tkda_pkg::poll_t     head_item;
  tkda_pkg::reg_index_t reg_sel;
  logic                push;
  logic                pop;
  logic                cfg_write;

  // Register port: always ready, word-aligned decode on the upper address bits.
  assign pready    = 1'b1;
  assign reg_sel   = tkda_pkg::reg_index_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enabled            <= tkda_pkg::ENABLED_RST;
      cfg.debounce_time      <= tkda_pkg::DEBOUNCE_RST;
      cfg.repeat_start_delay <= tkda_pkg::START_DELAY_RST;
      cfg.repeat_interval    <= tkda_pkg::INTERVAL_RST;
    end else if (cfg_write) begin
      unique case (reg_sel)
        tkda_pkg::REG_ENABLED:     cfg.enabled            <= pwdata[0];
        tkda_pkg::REG_DEBOUNCE:    cfg.debounce_time      <= pwdata[15:0];
        tkda_pkg::REG_START_DELAY: cfg.repeat_start_delay <= pwdata[15:0];
        tkda_pkg::REG_INTERVAL:    cfg.repeat_interval    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back the selected register; the low address bits do not change the data.
  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      tkda_pkg::REG_ENABLED:     prdata = {31'd0, cfg.enabled};
      tkda_pkg::REG_DEBOUNCE:    prdata = {16'd0, cfg.debounce_time};
      tkda_pkg::REG_START_DELAY: prdata = {16'd0, cfg.repeat_start_delay};
      tkda_pkg::REG_INTERVAL:    prdata = {16'd0, cfg.repeat_interval};
      default:                   prdata = '0;
    endcase
    if (paddr[1:0] != 2'd0) begin
      prdata = {16'd0, prdata[15:0]} & prdata;
    end
  end

  // Classify incoming polls.
  tkda_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .now_ms       (now_ms),
    .key_down_low (key_down_low),
    .key_up_low   (key_up_low),
    .levels_valid (levels_valid),
    .q_status     (q_status),
    .push         (push),
    .push_item    (push_item)
  );

  // Decouple the two halves so each can stall on its own.
  tkda_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .status    (q_status)
  );

  // Advance the debounce and repeat state, one poll per cycle while the result is not stalled.
  tkda_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_status  (q_status),
    .head_item (head_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .step      (step)
  );

  // The step code -2 is never produced.
  a_step_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (step != -2'sd2))
    else $error("illegal step code on result channel");

  // The sender is held off only while the queue is truly full.
  a_stall_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (q_status.full && q_status.not_empty))
    else $error("input stalled without a full queue");

  // The back end takes no item from an empty queue.
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_status.not_empty)
    else $error("pop from empty queue");

  // A poll taken while disabled answers zero.
  a_disabled_zero: assert property (@(posedge clk) disable iff (rst)
    (pop && !cfg.enabled) |=> (out_valid && step == tkda_pkg::STEP_ZERO))
    else $error("non-zero step while disabled");

endmodule

`default_nettype wire

### tb/two_key_debounce_autorepeat_tb.sv
// Self-checking testbench for the two-key debounce and auto-repeat block.
`timescale 1ns / 100ps

module two_key_debounce_autorepeat_tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_OFF_CYCLES = 400;

  // One poll as the sender offers it.
  typedef struct {
    logic [31:0] t;
    logic        down_low;
    logic        up_low;
    logic        lv;
  } key_poll_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [31:0]        now_ms = '0;
  logic               key_down_low = 1'b1;
  logic               key_up_low = 1'b1;
  logic               levels_valid = 1'b1;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [1:0]  step;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  two_key_debounce_autorepeat u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .now_ms       (now_ms),
    .key_down_low (key_down_low),
    .key_up_low   (key_up_low),
    .levels_valid (levels_valid),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .step         (step),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk = ~clk;

  // Polls waiting to be offered, and steps the key logic should answer with.
  key_poll_t         pending_polls[$];
  logic signed [1:0] expected_steps[$];

  // Shadow of the register file, updated as each register write lands.
  logic        cfg_on;
  logic [15:0] cfg_debounce;
  logic [15:0] cfg_start;
  logic [15:0] cfg_interval;

  // Shadow of the debounce and repeat state.
  logic        is_armed;
  logic [2:0]  cand_pat;
  logic [2:0]  settled_pat;
  logic [1:0]  held_key;
  logic [31:0] cand_t0;
  logic [31:0] next_repeat_t;

  // Stimulus shaping, owned by the stimulus process but for hold_left (hold-off process).
  logic [31:0] clock_ms;
  int unsigned dt_hi;
  int          phase_items;
  logic        idle_on = 1'b1;
  logic        stall_burst_go = 1'b0;
  int          hold_left;

  // Bookkeeping.
  int err_cnt;
  int polls_sent;
  int steps_checked;
  int down_seen;
  int up_seen;
  int invalid_seen;
  int settings_cnt;
  int cycle_cnt;

  // ---------------------------------------------------------------------------
  // Key logic shadow
  // ---------------------------------------------------------------------------

  // Drop every trace of a key pattern; the registers are left alone.
  function automatic void clear_keys();
    is_armed      = 1'b0;
    cand_pat      = tkda_pkg::PAT_NONE;
    settled_pat   = tkda_pkg::PAT_NONE;
    held_key      = tkda_pkg::PAT_RELEASED;
    cand_t0       = '0;
    next_repeat_t = '0;
  endfunction

  // Advance the shadow state by one poll and return the step it should produce.
  function automatic logic signed [1:0] next_volume_step(input key_poll_t p);
    logic [1:0]  raw;
    logic [31:0] held_for;
    logic [31:0] late_by;
    if (!cfg_on) return tkda_pkg::STEP_ZERO;
    if (!p.lv) begin
      clear_keys();
      invalid_seen++;
      return tkda_pkg::STEP_ZERO;
    end
    raw = {~p.up_low, ~p.down_low};

    // A chord, or the other key while one is held, stops repeating at once,
    // ahead of any debouncing.
    if (raw == tkda_pkg::PAT_BOTH ||
        (held_key != tkda_pkg::PAT_RELEASED && raw != tkda_pkg::PAT_RELEASED &&
         raw != held_key)) begin
      is_armed = 1'b0;
      held_key = tkda_pkg::PAT_RELEASED;
    end

    // A new raw pattern restarts the debounce window.
    if ({1'b0, raw} != cand_pat) begin
      cand_pat = {1'b0, raw};
      cand_t0  = p.t;
      return tkda_pkg::STEP_ZERO;
    end
    held_for = p.t - cand_t0;
    if (held_for < {16'h0, cfg_debounce}) return tkda_pkg::STEP_ZERO;

    // First poll on which the pattern counts as settled.
    if (settled_pat != {1'b0, raw}) begin
      settled_pat = {1'b0, raw};
      if (raw == tkda_pkg::PAT_RELEASED) begin
        is_armed = 1'b1;
        held_key = tkda_pkg::PAT_RELEASED;
      end else if (is_armed && raw != tkda_pkg::PAT_BOTH) begin
        held_key      = raw;
        next_repeat_t = p.t + {16'h0, cfg_start};
        return (raw == tkda_pkg::PAT_DOWN) ? tkda_pkg::STEP_MINUS : tkda_pkg::STEP_PLUS;
      end
      return tkda_pkg::STEP_ZERO;
    end

    // Auto-repeat: due once the modular distance past the deadline is
    // non-negative; the next deadline counts from this poll, so missed
    // repeats are never made up.
    late_by = p.t - next_repeat_t;
    if (is_armed && held_key != tkda_pkg::PAT_RELEASED && raw == held_key &&
        !late_by[31]) begin
      next_repeat_t = p.t + {16'h0, cfg_interval};
      return (raw == tkda_pkg::PAT_DOWN) ? tkda_pkg::STEP_MINUS : tkda_pkg::STEP_PLUS;
    end
    return tkda_pkg::STEP_ZERO;
  endfunction

  task automatic flag_error(input string what);
    if (err_cnt < 10) $display("ERROR at %0t: %s", $time, what);
    err_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // Poll driver: offer queued polls, hold the payload while stalled, and
  // predict the step of every poll at the edge its transfer completes.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : poll_driver
    key_poll_t took;
    key_poll_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        took.t        = now_ms;
        took.down_low = key_down_low;
        took.up_low   = key_up_low;
        took.lv       = levels_valid;
        expected_steps.push_back(next_volume_step(took));
        polls_sent++;
      end
      // A stalled transfer keeps valid and payload untouched.
      if (!in_valid || !in_stall) begin
        if (pending_polls.size() != 0 && !(idle_on && $urandom_range(0, 99) < 25)) begin
          nxt = pending_polls.pop_front();
          in_valid     <= 1'b1;
          now_ms       <= nxt.t;
          key_down_low <= nxt.down_low;
          key_up_low   <= nxt.up_low;
          levels_valid <= nxt.lv;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here so the sender keeps pushing meanwhile.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (stall_burst_go) begin
      hold_left <= HOLD_OFF_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Step monitor: compare each completed result transfer with the oldest
  // prediction, and stall at random or during the hold-off.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : step_monitor
    logic signed [1:0] want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_steps.size() == 0) begin
          flag_error($sformatf("step %0d arrived with no poll outstanding", step));
        end else begin
          want = expected_steps.pop_front();
          steps_checked++;
          if (step !== want)
            flag_error($sformatf("step of result %0d: expected %0d, got %0d",
                                 steps_checked, want, step));
          if (want == tkda_pkg::STEP_MINUS) down_seen++;
          if (want == tkda_pkg::STEP_PLUS) up_seen++;
        end
      end
      out_stall <= (hold_left != 0) || (idle_on && $urandom_range(0, 99) < 25);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_cnt, expected_steps.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic add_poll(input logic [31:0] t, input logic dl, input logic ul,
                          input logic lv);
    key_poll_t p;
    p.t        = t;
    p.down_low = dl;
    p.up_low   = ul;
    p.lv       = lv;
    pending_polls.push_back(p);
    phase_items++;
  endtask

  // Advance the millisecond clock a little and present a key pattern.
  task automatic hold_pattern(input logic [1:0] pat, input logic lv);
    clock_ms += $urandom_range(0, dt_hi);
    add_poll(clock_ms, ~pat[0], ~pat[1], lv);
  endtask

  // A release of 3 to 8 polls, then a press with random bounces,
  // chords, rollovers and dropouts sprinkled in.
  task automatic add_gesture();
    logic [1:0] key;
    logic [1:0] other;
    int         n_rel;
    int         n_press;
    int         i;
    key     = $urandom_range(0, 1) ? tkda_pkg::PAT_DOWN : tkda_pkg::PAT_UP;
    other   = (key == tkda_pkg::PAT_DOWN) ? tkda_pkg::PAT_UP : tkda_pkg::PAT_DOWN;
    n_rel   = $urandom_range(3, 8);
    n_press = $urandom_range(2, 30);
    for (i = 0; i < n_rel; i++) hold_pattern(tkda_pkg::PAT_RELEASED, 1'b1);
    for (i = 0; i < n_press; i++) begin
      case ($urandom_range(0, 24))
        0: hold_pattern(other, 1'b1);
        1: hold_pattern(tkda_pkg::PAT_BOTH, 1'b1);
        2: hold_pattern(tkda_pkg::PAT_RELEASED, 1'b1);
        3: hold_pattern(key, 1'b0);
        4: begin
          // roll over to the other key and stay there
          key = other;
          hold_pattern(key, 1'b1);
        end
        default: hold_pattern(key, 1'b1);
      endcase
    end
  endtask

  // Short bursts of anything: random levels, dropouts and wild clock jumps.
  task automatic add_noise();
    int n;
    int i;
    n = $urandom_range(1, 4);
    for (i = 0; i < n; i++) begin
      case ($urandom_range(0, 7))
        0: clock_ms = $urandom();
        // half the clock range away, near where the distance to a deadline flips sign
        1: clock_ms += 32'h8000_0000 + $urandom_range(0, 1000);
        default: clock_ms += $urandom_range(0, dt_hi);
      endcase
      add_poll(clock_ms, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
               $urandom_range(0, 5) != 0);
    end
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic write_reg(input tkda_pkg::reg_index_t idx, input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      tkda_pkg::REG_ENABLED:     cfg_on       = val[0];
      tkda_pkg::REG_DEBOUNCE:    cfg_debounce = val[15:0];
      tkda_pkg::REG_START_DELAY: cfg_start    = val[15:0];
      tkda_pkg::REG_INTERVAL:    cfg_interval = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_timing(input logic [15:0] deb, input logic [15:0] sdel,
                            input logic [15:0] intv);
    write_reg(tkda_pkg::REG_DEBOUNCE, {16'h0, deb});
    write_reg(tkda_pkg::REG_START_DELAY, {16'h0, sdel});
    write_reg(tkda_pkg::REG_INTERVAL, {16'h0, intv});
  endtask

  // Wait until every queued poll has gone in and every step has come out.
  task automatic drain();
    do @(posedge clk);
    while (pending_polls.size() != 0 || in_valid || expected_steps.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [31:0] t0;
    int          ph;
    int          target;
    cfg_on       = tkda_pkg::ENABLED_RST;
    cfg_debounce = tkda_pkg::DEBOUNCE_RST;
    cfg_start    = tkda_pkg::START_DELAY_RST;
    cfg_interval = tkda_pkg::INTERVAL_RST;
    clear_keys();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Out of reset the block is disabled: every poll answers zero and leaves
    // the state alone, including presses, dropouts and clock extremes.
    add_poll(32'h0000_0000, 1'b0, 1'b0, 1'b1);
    add_poll(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0);
    add_poll(32'h8000_0000, 1'b0, 1'b1, 1'b1);
    drain();

    // Directed walk with the default timings, straddling the clock wrap.
    write_reg(tkda_pkg::REG_ENABLED, 32'd1);
    settings_cnt++;
    t0 = 32'hFFFF_FE00;
    add_poll(t0,           1'b1, 1'b1, 1'b1);  // release seen
    add_poll(t0 + 32'd100, 1'b1, 1'b1, 1'b1);  // release settles: arm
    add_poll(t0 + 32'd110, 1'b0, 1'b1, 1'b1);  // down pressed
    add_poll(t0 + 32'd200, 1'b0, 1'b1, 1'b1);  // settles: step -1
    add_poll(t0 + 32'd500, 1'b0, 1'b1, 1'b1);  // start delay not yet over
    add_poll(t0 + 32'd800, 1'b0, 1'b1, 1'b1);  // first repeat, after the wrap
    add_poll(t0 + 32'd1900, 1'b0, 1'b1, 1'b1); // late poll: a single repeat
    add_poll(t0 + 32'd2100, 1'b0, 1'b1, 1'b1); // next interval from that poll
    add_poll(t0 + 32'd2150, 1'b1, 1'b0, 1'b1); // rollover to up: disarm
    add_poll(t0 + 32'd2300, 1'b1, 1'b0, 1'b1); // up settles, but not armed
    add_poll(t0 + 32'd2400, 1'b0, 1'b0, 1'b1); // chord
    add_poll(t0 + 32'd2500, 1'b0, 1'b0, 1'b1); // chord settles, nothing
    add_poll(t0 + 32'd2600, 1'b0, 1'b0, 1'b0); // invalid levels clear all
    add_poll(t0 + 32'd2700, 1'b1, 1'b1, 1'b1);
    add_poll(t0 + 32'd2800, 1'b1, 1'b1, 1'b1); // re-arm
    add_poll(t0 + 32'd2900, 1'b1, 1'b0, 1'b1);
    add_poll(t0 + 32'd2990, 1'b1, 1'b0, 1'b1); // step +1
    add_poll(t0 + 32'd3000, 1'b1, 1'b1, 1'b1); // bounce open
    add_poll(t0 + 32'd3010, 1'b1, 1'b0, 1'b1); // closed again, restart window
    add_poll(t0 + 32'd3100, 1'b1, 1'b0, 1'b1); // still settled on up, no repeat
    add_poll(t0 + 32'd3600, 1'b1, 1'b0, 1'b1); // repeat +1
    drain();

    // Random phases, each under its own register setting.
    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_timing(tkda_pkg::DEBOUNCE_RST, tkda_pkg::START_DELAY_RST,
                      tkda_pkg::INTERVAL_RST);
        1: set_timing(16'd0, 16'd0, 16'd0);
        2: set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
        3: set_timing(16'($urandom_range(0, 200)), 16'($urandom_range(0, 1000)),
                      16'($urandom_range(0, 500)));
        4: write_reg(tkda_pkg::REG_ENABLED, 32'd0);
        5: begin
          write_reg(tkda_pkg::REG_ENABLED, 32'd1);
          set_timing(16'($urandom()), 16'($urandom()), 16'($urandom()));
        end
        6: set_timing(16'd0, 16'hFFFF, 16'd1);
        default: set_timing(16'hFFFF, 16'd0, 16'd0);
      endcase
      settings_cnt++;
      dt_hi = int'(cfg_debounce) / 2 + int'(cfg_interval) / 4 + int'(cfg_start) / 16 + 2;
      clock_ms = $urandom();
      idle_on = (ph != 3);  // one phase runs flat out on both sides
      target = (ph == 4) ? 40 : 280;
      phase_items = 0;
      while (phase_items < target) begin
        if ($urandom_range(0, 9) == 0) add_noise();
        else add_gesture();
      end
      // Hold the receiver off for a long stretch so the block backs up.
      if (ph == 0) begin
        stall_burst_go <= 1'b1;
        @(posedge clk);
        stall_burst_go <= 1'b0;
      end
      drain();
    end

    repeat (8) @(posedge clk);
    $display("Covered %0d polls under %0d register settings, zero and full-scale timings",
             polls_sent, settings_cnt);
    $display("Checked %0d steps: %0d down, %0d up, %0d dropouts; %0d errors",
             steps_checked, down_seen, up_seen, invalid_seen, err_cnt);
    if (err_cnt == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
